>>> rtl/mandelbrot_pixel_colorizer_defines.svh
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_PIXEL_COLORIZER_DEFINES_SVH
`define MANDELBROT_PIXEL_COLORIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer package
// Number format, configuration record, reset values and color palette.
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

   localparam int COORD_BITS     = 32;
   localparam int FRAC_BITS      = COORD_BITS - 4;
   localparam int PROD_BITS      = 2 * COORD_BITS;
   localparam int SQ_BITS        = COORD_BITS - 1;
   localparam int ITER_BITS      = 16;
   localparam int DIM_FIELD_BITS = 13;
   localparam int COLOR_BITS     = 8;
   localparam int PALETTE_SIZE   = 16;
   localparam int PAL_IDX_BITS   = $clog2(PALETTE_SIZE);
   localparam int MAX_DIM_DEF    = 4096;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 5;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   // |z|^2 escape bound of 4.0 in the format of a saturated square sum
   localparam logic [SQ_BITS:0] ESCAPE_LIMIT =
      {{(SQ_BITS-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

   typedef struct packed {
      coord_type                 start_real;
      coord_type                 start_imag;
      coord_type                 step;
      logic [DIM_FIELD_BITS-1:0] frame_width;
      logic [DIM_FIELD_BITS-1:0] frame_height;
      logic [ITER_BITS-1:0]      max_iter;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      start_real:   coord_type'(-536870912),
      start_imag:   coord_type'(-268435456),
      step:         coord_type'(1677722),
      frame_width:  DIM_FIELD_BITS'(640),
      frame_height: DIM_FIELD_BITS'(480),
      max_iter:     ITER_BITS'(256)
   };

   typedef struct packed {
      logic [COLOR_BITS-1:0] blue;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] red;
   } color_type;

   function automatic color_type palette_lookup(input logic [PAL_IDX_BITS-1:0] idx);
      color_type c;
      unique case (idx)
         4'd0:    c = {8'd66,  8'd30,  8'd15};
         4'd1:    c = {8'd0,   8'd0,   8'd32};
         4'd2:    c = {8'd9,   8'd1,   8'd47};
         4'd3:    c = {8'd4,   8'd4,   8'd73};
         4'd4:    c = {8'd0,   8'd7,   8'd100};
         4'd5:    c = {8'd12,  8'd44,  8'd138};
         4'd6:    c = {8'd24,  8'd82,  8'd177};
         4'd7:    c = {8'd57,  8'd125, 8'd209};
         4'd8:    c = {8'd134, 8'd181, 8'd229};
         4'd9:    c = {8'd211, 8'd236, 8'd248};
         4'd10:   c = {8'd241, 8'd233, 8'd191};
         4'd11:   c = {8'd248, 8'd201, 8'd95};
         4'd12:   c = {8'd255, 8'd170, 8'd0};
         4'd13:   c = {8'd204, 8'd128, 8'd0};
         4'd14:   c = {8'd153, 8'd87,  8'd0};
         4'd15:   c = {8'd106, 8'd52,  8'd3};
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mpc_csr.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer register file
// APB-style slave holding the frame and iteration settings.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_csr import mpc_pkg::*; (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      psel,
   input  wire                      penable,
   input  wire                      pwrite,
   input  wire [CSR_ADDR_BITS-1:0]  paddr,
   input  wire [CSR_DATA_BITS-1:0]  pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   localparam int IDX_BITS = CSR_ADDR_BITS - 2;

   localparam logic [IDX_BITS-1:0] REG_START_REAL = IDX_BITS'(0);
   localparam logic [IDX_BITS-1:0] REG_START_IMAG = IDX_BITS'(1);
   localparam logic [IDX_BITS-1:0] REG_STEP       = IDX_BITS'(2);
   localparam logic [IDX_BITS-1:0] REG_WIDTH      = IDX_BITS'(3);
   localparam logic [IDX_BITS-1:0] REG_HEIGHT     = IDX_BITS'(4);
   localparam logic [IDX_BITS-1:0] REG_MAX_ITER   = IDX_BITS'(5);

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic [IDX_BITS-1:0] reg_idx;
   logic                wr_en;

   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_START_REAL: cfg_in.start_real   = coord_type'(pwdata);
            REG_START_IMAG: cfg_in.start_imag   = coord_type'(pwdata);
            REG_STEP:       cfg_in.step         = coord_type'(pwdata);
            REG_WIDTH:      cfg_in.frame_width  = pwdata[DIM_FIELD_BITS-1:0];
            REG_HEIGHT:     cfg_in.frame_height = pwdata[DIM_FIELD_BITS-1:0];
            REG_MAX_ITER:   cfg_in.max_iter     = pwdata[ITER_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_START_REAL: prdata = CSR_DATA_BITS'(unsigned'(cfg_ff.start_real));
         REG_START_IMAG: prdata = CSR_DATA_BITS'(unsigned'(cfg_ff.start_imag));
         REG_STEP:       prdata = CSR_DATA_BITS'(unsigned'(cfg_ff.step));
         REG_WIDTH:      prdata = CSR_DATA_BITS'(cfg_ff.frame_width);
         REG_HEIGHT:     prdata = CSR_DATA_BITS'(cfg_ff.frame_height);
         REG_MAX_ITER:   prdata = CSR_DATA_BITS'(cfg_ff.max_iter);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mpc_raster.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer raster walker
// Column and row counters with the running point c of the current pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_raster import mpc_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  wire       clock,
   input  wire       reset,
   input  wire       accept,
   input  wire       frame_start,
   input  cfg_type   cfg,
   output coord_type c_real,
   output coord_type c_imag,
   output logic      frame_last
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = CNT_W + 1;
   localparam int CMP_W = (DIM_W > DIM_FIELD_BITS) ? DIM_W : DIM_FIELD_BITS;

   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   coord_type        point_real_ff, point_real_in;
   coord_type        point_imag_ff, point_imag_in;

   logic [CNT_W-1:0] col_cur, row_cur;
   logic [CMP_W-1:0] col_next, row_next;
   logic [CMP_W-1:0] width_lim, height_lim;
   logic             col_wrap, row_wrap;

   function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_FIELD_BITS-1:0] d);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(d);
      if (d == '0) begin
         return CMP_W'(1);
      end
      if (ext > CMP_W'(MAX_DIM)) begin
         return CMP_W'(MAX_DIM);
      end
      return ext;
   endfunction

   // frame_start restarts at the corner before this pixel is taken
   assign col_cur = frame_start ? '0 : column_ff;
   assign row_cur = frame_start ? '0 : row_ff;
   assign c_real  = frame_start ? cfg.start_real : point_real_ff;
   assign c_imag  = frame_start ? cfg.start_imag : point_imag_ff;

   assign width_lim  = clamp_dim(cfg.frame_width);
   assign height_lim = clamp_dim(cfg.frame_height);
   assign col_next   = CMP_W'(col_cur) + CMP_W'(1);
   assign row_next   = CMP_W'(row_cur) + CMP_W'(1);
   assign col_wrap   = col_next >= width_lim;
   assign row_wrap   = row_next >= height_lim;
   assign frame_last = col_wrap & row_wrap;

   always_comb begin
      column_in     = column_ff;
      row_in        = row_ff;
      point_real_in = point_real_ff;
      point_imag_in = point_imag_ff;
      if (accept) begin
         if (col_wrap) begin
            column_in     = '0;
            point_real_in = cfg.start_real;
            if (row_wrap) begin
               row_in        = '0;
               point_imag_in = cfg.start_imag;
            end else begin
               row_in        = row_next[CNT_W-1:0];
               point_imag_in = c_imag + cfg.step;
            end
         end else begin
            column_in     = col_next[CNT_W-1:0];
            row_in        = row_cur;
            point_real_in = c_real + cfg.step;
            point_imag_in = c_imag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         point_real_ff <= CFG_RESET.start_real;
         point_imag_ff <= CFG_RESET.start_imag;
      end else begin
         column_ff     <= column_in;
         row_ff        <= row_in;
         point_real_ff <= point_real_in;
         point_imag_ff <= point_imag_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mpc_mul.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer multiplier
// Shared signed multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_mul import mpc_pkg::*; (
   input  wire                            clock,
   input  coord_type                      op_a,
   input  coord_type                      op_b,
   output logic signed [PROD_BITS-1:0]    prod
);

   logic signed [PROD_BITS-1:0] prod_ff, prod_in;

   assign prod_in = PROD_BITS'(op_a) * PROD_BITS'(op_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> rtl/mpc_iter.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer iteration engine
// Sequencer that runs z = z*z + c on the shared multiplier and colors the pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_iter import mpc_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  coord_type              c_real,
   input  coord_type              c_imag,
   input  wire                    frame_last,
   input  wire [ITER_BITS-1:0]    max_iter,
   input  wire                    rsp_stall,
   output logic                   busy,
   output logic                   rsp_valid,
   output logic [COLOR_BITS-1:0]  rsp_blue,
   output logic [COLOR_BITS-1:0]  rsp_green,
   output logic [COLOR_BITS-1:0]  rsp_red,
   output logic [ITER_BITS-1:0]   rsp_iter_count,
   output logic                   rsp_inside_set,
   output logic                   rsp_frame_end
);

   localparam int XY_W  = PROD_BITS - FRAC_BITS + 1;
   localparam int NZI_W = XY_W + 1;
   localparam int NZR_W = COORD_BITS + 2;
   localparam int SQ_W  = PROD_BITS - FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_UPDATE,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   coord_type            cr_ff, cr_in;
   coord_type            ci_ff, ci_in;
   logic                 last_ff, last_in;
   coord_type            zr_ff, zr_in;
   coord_type            zi_ff, zi_in;
   logic [SQ_BITS-1:0]   zr2_ff, zr2_in;
   logic [SQ_BITS-1:0]   zi2_ff, zi2_in;
   logic                 ovf_ff, ovf_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic                 inside_ff, inside_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   color_type             color_ff, color_in;
   logic [ITER_BITS-1:0]  rsp_iter_ff, rsp_iter_in;
   logic                  rsp_inside_ff, rsp_inside_in;
   logic                  rsp_end_ff, rsp_end_in;

   coord_type                   mul_a, mul_b;
   logic signed [PROD_BITS-1:0] prod;

   logic signed [XY_W-1:0]     xy_scaled;
   logic signed [NZI_W-1:0]    nzi_sum;
   logic signed [NZR_W-1:0]    nzr_sum;
   logic [NZI_W-COORD_BITS:0]  nzi_hi;
   logic [NZR_W-COORD_BITS:0]  nzr_hi;
   coord_type                  nzi_sat, nzr_sat;
   logic [SQ_W-1:0]            sq;
   logic                       sq_ovf;
   logic [SQ_BITS-1:0]         sq_sat;
   logic [SQ_BITS:0]           mag;
   logic                       escape;
   logic [ITER_BITS-1:0]       iter_next;
   logic                       last_iter;
   logic                       out_free;

   mpc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // one product per cycle: zr*zi, then zr*zr, then zi*zi
   always_comb begin
      case (state_ff)
         ST_SQ_RE: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_SQ_IM: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   // 2*zr*zi + ci and zr^2 - zi^2 + cr, saturated to the coordinate range
   assign xy_scaled = $signed(prod[PROD_BITS-1:FRAC_BITS-1]);
   assign nzi_sum   = NZI_W'(xy_scaled) + NZI_W'(ci_ff);
   assign nzr_sum   = $signed(NZR_W'(zr2_ff)) - $signed(NZR_W'(zi2_ff)) + NZR_W'(cr_ff);
   assign nzi_hi    = nzi_sum[NZI_W-1:COORD_BITS-1];
   assign nzr_hi    = nzr_sum[NZR_W-1:COORD_BITS-1];
   assign nzi_sat   = ((&nzi_hi) | ~(|nzi_hi)) ? nzi_sum[COORD_BITS-1:0] :
                      (nzi_sum[NZI_W-1] ? COORD_MIN : COORD_MAX);
   assign nzr_sat   = ((&nzr_hi) | ~(|nzr_hi)) ? nzr_sum[COORD_BITS-1:0] :
                      (nzr_sum[NZR_W-1] ? COORD_MIN : COORD_MAX);

   // squares are never negative; clip to the largest coordinate
   assign sq     = prod[PROD_BITS-1:FRAC_BITS];
   assign sq_ovf = |sq[SQ_W-1:SQ_BITS];
   assign sq_sat = sq_ovf ? {SQ_BITS{1'b1}} : sq[SQ_BITS-1:0];

   assign mag       = (SQ_BITS+1)'(zr2_ff) + (SQ_BITS+1)'(sq_sat);
   assign escape    = ovf_ff | sq_ovf | (mag > ESCAPE_LIMIT);
   assign iter_next = iter_ff + ITER_BITS'(1);
   assign last_iter = iter_next == max_iter;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      last_in       = last_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      zr2_in        = zr2_ff;
      zi2_in        = zi2_ff;
      ovf_in        = ovf_ff;
      iter_in       = iter_ff;
      inside_in     = inside_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      color_in      = color_ff;
      rsp_iter_in   = rsp_iter_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_end_in    = rsp_end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cr_in     = c_real;
               ci_in     = c_imag;
               last_in   = frame_last;
               zr_in     = '0;
               zi_in     = '0;
               zr2_in    = '0;
               zi2_in    = '0;
               ovf_in    = 1'b0;
               iter_in   = '0;
               inside_in = 1'b1;
               // a zero limit runs no iteration at all
               state_in  = (max_iter == '0) ? ST_DONE : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            zr_in    = nzr_sat;
            zi_in    = nzi_sat;
            state_in = ST_SQ_RE;
         end
         ST_SQ_RE: begin
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            zr2_in   = sq_sat;
            ovf_in   = sq_ovf;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            zi2_in  = sq_sat;
            iter_in = iter_next;
            if (escape || last_iter) begin
               inside_in = last_iter;
               state_in  = ST_DONE;
            end else begin
               state_in  = ST_UPDATE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               color_in      = inside_ff ? '0 : palette_lookup(iter_ff[PAL_IDX_BITS-1:0]);
               rsp_iter_in   = iter_ff;
               rsp_inside_in = inside_ff;
               rsp_end_in    = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      last_ff       <= last_in;
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      zr2_ff        <= zr2_in;
      zi2_ff        <= zi2_in;
      ovf_ff        <= ovf_in;
      iter_ff       <= iter_in;
      inside_ff     <= inside_in;
      color_ff      <= color_in;
      rsp_iter_ff   <= rsp_iter_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blue       = color_ff.blue;
   assign rsp_green      = color_ff.green;
   assign rsp_red        = color_ff.red;
   assign rsp_iter_count = rsp_iter_ff;
   assign rsp_inside_set = rsp_inside_ff;
   assign rsp_frame_end  = rsp_end_ff;

endmodule

`default_nettype wire

>>> rtl/mandelbrot_pixel_colorizer.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer
// Escape-time renderer with a 16-color palette, one pixel per input item.
// ----------------------------------------------------------------------------
// Each input item renders the next pixel of the frame in raster order and
// returns one colored result. A pixel runs up to max_iter iterations; one
// 32x32 multiplier is shared for the products zr*zi, zr*zr and zi*zi of
// every iteration, and a separate update step forms the new z. A zero limit
// runs no iteration. The block takes no new item while a pixel is being
// iterated; a finished pixel sits in an output register, so the next item is
// taken while it waits. There is no clearing pass.
`default_nettype none

module mandelbrot_pixel_colorizer import mpc_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire                      req_frame_start,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [COLOR_BITS-1:0]    rsp_blue,
   output logic [COLOR_BITS-1:0]    rsp_green,
   output logic [COLOR_BITS-1:0]    rsp_red,
   output logic [ITER_BITS-1:0]     rsp_iter_count,
   output logic                     rsp_inside_set,
   output logic                     rsp_frame_end,
   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type   cfg;
   coord_type c_real, c_imag;
   logic      frame_last;
   logic      accept;
   logic      busy;

   assign req_stall = busy;
   assign accept    = req_valid & ~busy;

   mpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   mpc_raster #(
      .MAX_DIM (MAX_DIM)
   ) u_raster (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_frame_start),
      .cfg         (cfg),
      .c_real      (c_real),
      .c_imag      (c_imag),
      .frame_last  (frame_last)
   );

   mpc_iter u_iter (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .c_real         (c_real),
      .c_imag         (c_imag),
      .frame_last     (frame_last),
      .max_iter       (cfg.max_iter),
      .rsp_stall      (rsp_stall),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_blue       (rsp_blue),
      .rsp_green      (rsp_green),
      .rsp_red        (rsp_red),
      .rsp_iter_count (rsp_iter_count),
      .rsp_inside_set (rsp_inside_set),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

`default_nettype wire

>>> rtl/mpc_checker.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer checker
// Port-level assertions on the pixel channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_pixel_colorizer_defines.svh"

module mpc_checker import mpc_pkg::*; (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input wire [COLOR_BITS-1:0]  rsp_blue,
   input wire [COLOR_BITS-1:0]  rsp_green,
   input wire [COLOR_BITS-1:0]  rsp_red,
   input wire [ITER_BITS-1:0]   rsp_iter_count,
   input wire                   rsp_inside_set,
   input wire                   rsp_frame_end
);

   // an accepted item makes the block busy in the cycle after it is taken
   `MPC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "item accepted but block not busy")

   // pixels inside the set are black
   `MPC_ASSERT_IMP(a_inside_black, clock, reset, rsp_valid && rsp_inside_set, rsp_blue == 8'd0 && rsp_green == 8'd0 && rsp_red == 8'd0, "inside pixel not black")

   // a new result only appears out of a busy engine
   `MPC_ASSERT_IMP(a_result_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "result without work in progress")

   `MPC_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_iter_count) && $stable(rsp_inside_set) && $stable(rsp_frame_end), "stalled result changed")

endmodule

bind mandelbrot_pixel_colorizer mpc_checker u_checker (.*);

`default_nettype wire
